@@ rtl/core/frame_animation_sequencer_top_defines.svh @@
// assertion macros shared by the frame animation sequencer rtl
`ifndef FRAME_ANIMATION_SEQUENCER_TOP_DEFINES_SVH
`define FRAME_ANIMATION_SEQUENCER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FAS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fas assertion failed");

// antecedent implies consequent in the following cycle
`define FAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fas assertion failed");

`endif

@@ rtl/core/fas_pkg.sv @@
// types and constants of the frame animation sequencer
package fas_pkg;

  localparam int unsigned TIME_BITS = 16;
  localparam int unsigned FRAME_BITS = 8;
  localparam int unsigned REP_BITS = 8;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = (TIME_BITS > 8) ? TIME_BITS : 8;

  localparam logic [FRAME_BITS-1:0] END_MARK = '1;
  localparam logic [REP_BITS-1:0] FOREVER = '1;

  localparam logic [1:0] FUNC_CONT = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_TIME = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LAST_FRAME = 2'd2;

  typedef struct packed {
    logic [REP_BITS-1:0]   repeat_count;
    logic [TIME_BITS-1:0]  frame_time;
    logic [FRAME_BITS-1:0] last_frame;
  } cfg_t;

  typedef struct packed {
    logic [REP_BITS-1:0]   repeats_left;
    logic [TIME_BITS-1:0]  time_left;
    logic [FRAME_BITS-1:0] frame_now;
  } seq_state_t;

endpackage

@@ rtl/core/fas_step.sv @@
// next-state and frame logic for one sequencer tick
module fas_step (
  input  fas_pkg::cfg_t                  cfg_i,
  input  fas_pkg::seq_state_t            cur_i,
  input  logic [1:0]                     func_i,
  input  logic [fas_pkg::TIME_BITS-1:0]  elapsed_i,
  output fas_pkg::seq_state_t            nxt_o,
  output logic [fas_pkg::FRAME_BITS-1:0] frame_o
);

  fas_pkg::seq_state_t halt;
  fas_pkg::seq_state_t s;
  logic [fas_pkg::TIME_BITS-1:0] dec;
  logic stale;
  logic do_count;

  assign halt.repeats_left = '0;
  assign halt.time_left = '0;
  assign halt.frame_now = fas_pkg::END_MARK;

  assign dec = (cur_i.time_left > elapsed_i) ? (cur_i.time_left - elapsed_i) : '0;
  assign stale = (cfg_i.repeat_count < cur_i.repeats_left) ||
                 (cfg_i.frame_time < cur_i.time_left) ||
                 (cfg_i.last_frame < cur_i.frame_now);
  assign s = stale ? halt : cur_i;

  always_comb begin
    nxt_o = s;
    frame_o = s.frame_now;
    do_count = 1'b0;
    case (func_i)
      fas_pkg::FUNC_STOP: begin
        nxt_o = halt;
        frame_o = fas_pkg::END_MARK;
      end
      fas_pkg::FUNC_START: begin
        if (s.time_left == '0) begin
          if ((cfg_i.repeat_count <= s.repeats_left) || (s.repeats_left == '0)) begin
            nxt_o.repeats_left = cfg_i.repeat_count;
          end
          nxt_o.time_left = cfg_i.frame_time;
          if (s.frame_now == fas_pkg::END_MARK) begin
            nxt_o.frame_now = '0;
          end
          frame_o = nxt_o.frame_now;
        end else begin
          do_count = 1'b1;
        end
      end
      default: begin
        if ((s.time_left == '0) || (s.frame_now == fas_pkg::END_MARK)) begin
          frame_o = fas_pkg::END_MARK;
        end else begin
          do_count = 1'b1;
        end
      end
    endcase

    // count-down path, only reached while running so the state is not stale
    if (do_count) begin
      if (dec == '0) begin
        nxt_o.time_left = cfg_i.frame_time;
        if (cfg_i.last_frame > s.frame_now) begin
          nxt_o.frame_now = s.frame_now + 1'b1;
        end else begin
          nxt_o.frame_now = '0;
          if (s.repeats_left != fas_pkg::FOREVER) begin
            if (s.repeats_left != '0) begin
              nxt_o.repeats_left = s.repeats_left - 1'b1;
            end else begin
              // end of play
              nxt_o.repeats_left = cfg_i.repeat_count;
              nxt_o.time_left = '0;
              nxt_o.frame_now = fas_pkg::END_MARK;
            end
          end
        end
      end else begin
        nxt_o.time_left = dec;
      end
      frame_o = nxt_o.frame_now;
    end
  end

endmodule

@@ rtl/core/frame_animation_sequencer_top.sv @@
// top level of the frame animation sequencer
//
// input channel: in_valid_i / in_stall_o carry one transaction per timer tick,
// a command (func_i) and the time passed since the previous tick (elapsed_i).
// output channel: out_valid_o / out_stall_i carry one transaction per input,
// the frame to show on frame_o, or 255 once the animation has ended.
// a transaction moves at a rising edge with valid high and stall low.
// configuration: cfg_we_i writes cfg_wdata_i into the register cfg_index_i
// (0 repeat count, 1 frame time, 2 last frame); write only while idle.
// the result appears on the output register in the cycle after the
// input is taken. throughput: one transaction per cycle unless a full output
// register is stalled, set by the single update of the sequencer state registers.
// when the receiver stalls, the result holds and the input stalls only if
// the output register is full and not being drained in the same cycle.
// reset (rst_ni low, asynchronous) clears the configuration registers to 0, the sequencer
// state to stopped with frame 255, and empties the output register.
`include "frame_animation_sequencer_top_defines.svh"

module frame_animation_sequencer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fas_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [fas_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          func_i,
  input  logic [fas_pkg::TIME_BITS-1:0]       elapsed_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [fas_pkg::FRAME_BITS-1:0]      frame_o
);

  fas_pkg::cfg_t cfg_q;
  fas_pkg::seq_state_t state_q, state_d;
  logic [fas_pkg::FRAME_BITS-1:0] frame_q, frame_d;
  logic out_valid_q;
  logic in_acc;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fas_pkg::REG_REPEAT_COUNT: cfg_q.repeat_count <= cfg_wdata_i[fas_pkg::REP_BITS-1:0];
        fas_pkg::REG_FRAME_TIME:   cfg_q.frame_time <= cfg_wdata_i[fas_pkg::TIME_BITS-1:0];
        fas_pkg::REG_LAST_FRAME:   cfg_q.last_frame <= cfg_wdata_i[fas_pkg::FRAME_BITS-1:0];
        default: ;
      endcase
    end
  end

  fas_step u_step (
    .cfg_i     (cfg_q),
    .cur_i     (state_q),
    .func_i    (func_i),
    .elapsed_i (elapsed_i),
    .nxt_o     (state_d),
    .frame_o   (frame_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.repeats_left <= '0;
      state_q.time_left <= '0;
      state_q.frame_now <= fas_pkg::END_MARK;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        state_q <= state_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded only with a new transaction
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      frame_q <= frame_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign frame_o = frame_q;

  `FAS_ASSERT_NEXT(a_acc_gives_result, in_acc, out_valid_q)
  `FAS_ASSERT_NEXT(a_stop_ends, in_acc && (func_i == fas_pkg::FUNC_STOP),
    (frame_q == fas_pkg::END_MARK) && (state_q.time_left == '0))
  `FAS_ASSERT_SAME(a_no_overwrite, out_valid_q && out_stall_i, !in_acc)
  `FAS_ASSERT_NEXT(a_idle_holds_state, !in_acc, $stable(state_q))

endmodule
